@@ sv/cdau_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Request codes, pipeline stage record and month length helper.
// ----------------------------------------------------------------------------
package cdau_pkg;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_SUB   = 2'd1;
    localparam logic [1:0] REQ_LESS  = 2'd2;
    localparam logic [1:0] REQ_VALID = 2'd3;

    // floor(2^22 / 25): quotient estimate for the divisible-by-25 test
    localparam int unsigned RECIP25_SHIFT = 22;
    localparam logic [17:0] RECIP25       = 18'd167772;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] year;   // year used for the month length lookup
        logic signed [5:0]  month;  // month used for the month length lookup
        logic signed [6:0]  day;    // day sum, day difference or raw day
        logic               flag;   // compare result
    } stage_t;

    function automatic logic [4:0] month_len(input logic signed [5:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m) inside
                6'sd4, 6'sd6, 6'sd9, 6'sd11: len = 5'd30;
                6'sd2:                       len = leap ? 5'd29 : 5'd28;
                default:                     len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

@@ sv/cdau_leap.sv @@
// ----------------------------------------------------------------------------
// Leap year pipe
// Two-stage leap test: |y| times a reciprocal of 25, then remainder check.
// ----------------------------------------------------------------------------
module cdau_leap
    import cdau_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] year,
    output logic               leap
);

    logic [15:0] abs_year;
    logic [15:0] a_reg;
    logic [33:0] prod_reg;
    logic [11:0] quot;
    logic [15:0] rem;
    logic        div25;
    logic        leap_next;
    logic        leap_reg;

    // magnitude of -32768 is 32768, still fits 16 bits unsigned
    assign abs_year = year[15] ? 16'(-year) : 16'(year);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= abs_year;
            prod_reg <= 34'(abs_year) * 34'(RECIP25);
        end
    end

    // estimate is floor(a/25) or one less, so remainder is below 50
    assign quot  = prod_reg[33:RECIP25_SHIFT];
    assign rem   = a_reg - 16'({quot, 4'd0} + {1'b0, quot, 3'd0} + {4'd0, quot});
    assign div25 = (rem == 16'd0) || (rem == 16'd25);

    // div by 400 = div by 16 and 25; div by 4 but not 100 = div by 4, not 25
    assign leap_next = (div25 && (a_reg[3:0] == 4'd0)) || (!div25 && (a_reg[1:0] == 2'd0));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            leap_reg <= leap_next;
        end
    end

    assign leap = leap_reg;

endmodule

@@ sv/calendar_date_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Calendar date arithmetic unit
// Gregorian date add/subtract of a period, date compare and validity check.
// Throughput: one item per cycle; the four-stage pipe stalls as a whole
// when the output register is full and not taken.
// Reset: valid bits cleared asynchronously; no clearing pass.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_unit
    import cdau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [4:0]         date_day,
    input  logic [3:0]         date_month,
    input  logic signed [15:0] date_year,
    input  logic [4:0]         other_day,
    input  logic [3:0]         other_month,
    input  logic signed [15:0] other_year,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         res_day,
    output logic [3:0]         res_month,
    output logic signed [15:0] res_year,
    output logic               flag
);

    logic   adv;
    stage_t s1_next;
    stage_t s1_reg;
    stage_t s2_reg;
    stage_t s3_reg;
    logic   v1_reg;
    logic   v2_reg;
    logic   v3_reg;
    logic   v4_reg;
    logic   leap;

    logic [5:0]         res_day_next;
    logic [3:0]         res_month_next;
    logic signed [15:0] res_year_next;
    logic               flag_next;
    logic [5:0]         res_day_reg;
    logic [3:0]         res_month_reg;
    logic signed [15:0] res_year_reg;
    logic               flag_reg;

    assign adv      = !v4_reg || out_ready;
    assign in_ready = adv;

    // ---------------- stage 1: month and day steps, year adder ------------
    logic [4:0]         add_m;
    logic               add_c;
    logic signed [5:0]  sub_md;
    logic signed [5:0]  sub_m1;
    logic signed [6:0]  sub_df;
    logic               sub_b1;
    logic               sub_b2;
    logic [1:0]         sub_b;
    logic               less;

    always_comb
    begin
        add_m  = 5'({1'b0, date_month} + {1'b0, other_month});
        add_c  = (add_m > 5'd12);

        sub_md = $signed({2'b00, date_month}) - $signed({2'b00, other_month});
        sub_b1 = (sub_md <= 6'sd0);
        sub_m1 = sub_b1 ? 6'(sub_md + 6'sd12) : sub_md;
        sub_df = $signed({2'b00, date_day}) - $signed({2'b00, other_day});
        sub_b2 = (sub_df <= 7'sd0) && (sub_m1 == 6'sd1);
        sub_b  = {1'b0, sub_b1} + {1'b0, sub_b2};

        if (date_year != other_year)
            less = (date_year < other_year);
        else if (date_month != other_month)
            less = (date_month < other_month);
        else
            less = (date_day < other_day);

        s1_next       = '0;
        s1_next.kind  = req_type;
        case (req_type)
            REQ_ADD:
            begin
                s1_next.year  = 16'(date_year + other_year + 16'(add_c));
                s1_next.month = add_c ? 6'(add_m - 5'd12) : 6'(add_m);
                s1_next.day   = 7'({2'b00, date_day} + {2'b00, other_day});
            end
            REQ_SUB:
            begin
                s1_next.year  = 16'(date_year - other_year - 16'(sub_b));
                if (sub_df <= 7'sd0)
                    s1_next.month = (sub_m1 != 6'sd1) ? 6'(sub_m1 - 6'sd1) : 6'sd12;
                else
                    s1_next.month = sub_m1;
                s1_next.day   = sub_df;
            end
            REQ_LESS:
            begin
                s1_next.flag  = less;
            end
            default:
            begin
                s1_next.year  = date_year;
                s1_next.month = $signed({2'b00, date_month});
                s1_next.day   = $signed({2'b00, date_day});
            end
        endcase
    end

    // ---------------- stages 2 and 3: leap test on the lookup year --------
    cdau_leap u_leap
    (
        .clk  (clk),
        .en   (adv),
        .year (s1_reg.year),
        .leap (leap)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    // ---------------- stage 4: single carry/borrow and validity check with month length
    logic [4:0]        len;
    logic signed [6:0] len_s;
    logic signed [6:0] sub_day;

    always_comb
    begin
        len            = month_len(s3_reg.month, leap);
        len_s          = $signed({2'b00, len});
        sub_day        = 7'(s3_reg.day + len_s);
        res_day_next   = '0;
        res_month_next = '0;
        res_year_next  = '0;
        flag_next      = 1'b0;
        case (s3_reg.kind)
            REQ_ADD:
            begin
                res_year_next  = s3_reg.year;
                res_month_next = s3_reg.month[3:0];
                res_day_next   = s3_reg.day[5:0];
                if (s3_reg.day > len_s)
                begin
                    if ((len == 5'd31) && (s3_reg.month == 6'sd12))
                    begin
                        res_month_next = 4'd1;
                        res_year_next  = 16'(s3_reg.year + 16'sd1);
                    end
                    else
                    begin
                        res_month_next = 4'(s3_reg.month + 6'sd1);
                    end
                    res_day_next = 6'(s3_reg.day - len_s);
                end
            end
            REQ_SUB:
            begin
                res_year_next  = s3_reg.year;
                res_month_next = s3_reg.month[3:0];
                res_day_next   = (s3_reg.day <= 7'sd0) ? sub_day[5:0] : s3_reg.day[5:0];
            end
            REQ_LESS:
            begin
                flag_next = s3_reg.flag;
            end
            default:
            begin
                flag_next = (s3_reg.month >= 6'sd1) && (s3_reg.month <= 6'sd12)
                         && (s3_reg.day >= 7'sd1) && (s3_reg.day <= len_s);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_day_reg   <= res_day_next;
            res_month_reg <= res_month_next;
            res_year_reg  <= res_year_next;
            flag_reg      <= flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign res_day   = res_day_reg;
    assign res_month = res_month_reg;
    assign res_year  = res_year_reg;
    assign flag      = flag_reg;

`ifndef SYNTH
    // an empty output slot never holds back the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // compare and validity items carry no date
    a_flag_no_date: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && flag) |-> (res_day == 6'd0 && res_month == 4'd0 && res_year == 16'sd0))
        else $error("flagged result carries a date");

    // a stalled output freezes the whole pipe
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(v1_reg) && $stable(v2_reg) && $stable(v3_reg)
                                       && $stable(s3_reg)))
        else $error("pipeline moved during output stall");
`endif

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Calendar date arithmetic unit testbench
// Drives add, subtract, compare and validity requests through the valid/ready
// input, predicts every result with a local Gregorian date model and checks
// each output item, field by field, in order. Both sides idle and stall at
// random; one stretch lets the pipe drain before sending resumes.
// ----------------------------------------------------------------------------
module tb
    import cdau_pkg::*;
();

    typedef struct packed {
        logic [5:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic        flag;
    } date_res_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic [4:0]         date_day;
    logic [3:0]         date_month;
    logic signed [15:0] date_year;
    logic [4:0]         other_day;
    logic [3:0]         other_month;
    logic signed [15:0] other_year;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [5:0]         res_day;
    logic [3:0]         res_month;
    logic signed [15:0] res_year;
    logic               flag;

    date_res_t expected_dates[$];
    date_res_t want;
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    calendar_date_arithmetic_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .date_day    (date_day),
        .date_month  (date_month),
        .date_year   (date_year),
        .other_day   (other_day),
        .other_month (other_month),
        .other_year  (other_year),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .res_day     (res_day),
        .res_month   (res_month),
        .res_year    (res_year),
        .flag        (flag)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // ------------------------------------------------------------------------
    // Date model
    // ------------------------------------------------------------------------
    function automatic bit leap_year(int y);
        int a;
        a = (y < 0) ? -y : y;
        return (a % 400 == 0) || (a % 4 == 0 && a % 100 != 0);
    endfunction

    // anything outside 4/6/9/11/2 counts as 31 days, out-of-range months too
    function automatic int days_in_month(int m, int y);
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        return 31;
    endfunction

    function automatic int wrap_year(int y);
        logic signed [15:0] w;
        w = y[15:0];
        return int'(w);
    endfunction

    function automatic date_res_t predict_date(logic [1:0] kind, int dd, int dm, int dy,
                                               int od, int om, int oy);
        date_res_t r;
        int        ry;
        int        rm;
        int        rd;
        int        s;
        int        len;
        r  = '0;
        ry = 0;
        rm = 0;
        rd = 0;
        case (kind)
            REQ_ADD:
            begin
                ry = wrap_year(dy + oy);
                rm = dm + om;
                if (rm > 12)
                begin
                    ry = wrap_year(ry + 1);
                    rm -= 12;
                end
                s   = dd + od;
                len = days_in_month(rm, ry);
                // single carry into the next month
                if (s > len)
                begin
                    if (len == 31 && rm == 12)
                    begin
                        rm = 1;
                        ry = wrap_year(ry + 1);
                    end
                    else
                        rm += 1;
                    s -= len;
                end
                rd = s;
            end
            REQ_SUB:
            begin
                ry = wrap_year(dy - oy);
                rm = dm - om;
                if (rm <= 0)
                begin
                    ry = wrap_year(ry - 1);
                    rm += 12;
                end
                s = dd - od;
                // single borrow, length taken from the month borrowed from
                if (s <= 0)
                begin
                    if (rm != 1)
                        rm -= 1;
                    else
                    begin
                        rm = 12;
                        ry = wrap_year(ry - 1);
                    end
                    rd = s + days_in_month(rm, ry);
                end
                else
                    rd = s;
            end
            REQ_LESS:
            begin
                if (dy != oy)
                    r.flag = (dy < oy);
                else if (dm != om)
                    r.flag = (dm < om);
                else
                    r.flag = (dd < od);
            end
            default:
            begin
                if (dm >= 1 && dm <= 12)
                    r.flag = (dd >= 1 && dd <= days_in_month(dm, dy));
            end
        endcase
        r.day   = rd[5:0];
        r.month = rm[3:0];
        r.year  = ry[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dates.size() == 0)
            begin
                $display({"%0t: unexpected item, expected none, ",
                          "actual day %0d month %0d year %0d flag %0b"},
                         $time, res_day, res_month, res_year, flag);
                errors++;
            end
            else
            begin
                want = expected_dates.pop_front();
                if (res_day !== want.day)
                begin
                    $display("%0t: res_day expected %0d actual %0d", $time, want.day, res_day);
                    errors++;
                end
                if (res_month !== want.month)
                begin
                    $display("%0t: res_month expected %0d actual %0d", $time, want.month,
                             res_month);
                    errors++;
                end
                if (res_year !== want.year)
                begin
                    $display("%0t: res_year expected %0d actual %0d", $time,
                             $signed(want.year), res_year);
                    errors++;
                end
                if (flag !== want.flag)
                begin
                    $display("%0t: flag expected %0b actual %0b", $time, want.flag, flag);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender; called and returns at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_req(input logic [1:0] kind, input logic [4:0] dd, input logic [3:0] dm,
                            input logic signed [15:0] dy, input logic [4:0] od,
                            input logic [3:0] om, input logic signed [15:0] oy);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        date_day    <= dd;
        date_month  <= dm;
        date_year   <= dy;
        other_day   <= od;
        other_month <= om;
        other_year  <= oy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_dates.push_back(predict_date(kind, int'(dd), int'(dm), int'(dy),
                                              int'(od), int'(om), int'(oy)));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_dates.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_random_req();
        logic [1:0]         kind;
        logic [4:0]         dd;
        logic [4:0]         od;
        logic [3:0]         dm;
        logic [3:0]         om;
        logic signed [15:0] dy;
        logic signed [15:0] oy;
        kind = 2'($urandom_range(0, 3));
        dd   = 5'($urandom);
        dm   = 4'($urandom);
        dy   = 16'($urandom);
        od   = 5'($urandom);
        om   = 4'($urandom);
        oy   = 16'($urandom);
        // mostly a valid first date with a sensible second operand, rest is noise
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 3))
                0: dy = 16'(int'($urandom_range(0, 4000)) - 2000);
                1: dy = 16'((int'($urandom_range(0, 160)) - 80) * 100);
                2: dy = 16'(16'h7FFC + $urandom_range(0, 7));
                default: dy = 16'($urandom);
            endcase
            dm = 4'($urandom_range(1, 12));
            dd = 5'($urandom_range(1, days_in_month(int'(dm), int'(dy))));
            case (kind)
                REQ_ADD, REQ_SUB:
                begin
                    if ($urandom_range(0, 3) != 0)
                        oy = 16'($urandom_range(0, 20));
                    om = 4'($urandom_range(0, 12));
                    od = 5'($urandom_range(0, 31));
                end
                REQ_LESS:
                begin
                    oy = dy;
                    om = dm;
                    od = dd;
                    case ($urandom_range(0, 3))
                        0: oy = 16'(int'(dy) + int'($urandom_range(0, 2)) - 1);
                        1: om = 4'($urandom_range(1, 12));
                        2: od = 5'($urandom_range(0, 31));
                        default: ;
                    endcase
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        dd = 5'($urandom_range(27, 31));
                    if ($urandom_range(0, 3) == 0)
                        dm = 4'($urandom);
                end
            endcase
        end
        send_req(kind, dd, dm, dy, od, om, oy);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_add_period();
        send_req(REQ_ADD, 31, 12, 2023, 1, 0, 0);        // carry into next year
        send_req(REQ_ADD, 28, 2, 2024, 1, 0, 0);         // leap February
        send_req(REQ_ADD, 28, 2, 1900, 1, 0, 0);         // century, not leap
        send_req(REQ_ADD, 29, 2, 2000, 1, 0, 0);         // 400 rule, then carry
        send_req(REQ_ADD, 15, 11, 2023, 15, 3, 0);       // month wrap, then day carry
        send_req(REQ_ADD, 31, 15, 32767, 31, 15, 32767); // fields at their maximum, year overflow
        send_req(REQ_ADD, 0, 0, -32768, 0, 0, -32768);
    endtask

    task automatic test_sub_period();
        send_req(REQ_SUB, 1, 1, 2024, 1, 0, 0);          // borrow back into December
        send_req(REQ_SUB, 1, 3, 2024, 1, 0, 0);
        send_req(REQ_SUB, 1, 3, 2100, 1, 0, 0);
        send_req(REQ_SUB, 10, 1, 2024, 0, 2, 0);         // month borrow
        send_req(REQ_SUB, 0, 0, -32768, 31, 15, 32767);  // negative day and month
        send_req(REQ_SUB, 31, 15, 32767, 0, 0, -32768);
    endtask

    task automatic test_date_compare();
        send_req(REQ_LESS, 5, 6, 2020, 5, 6, 2020);      // equal dates
        send_req(REQ_LESS, 1, 1, -32768, 1, 1, 32767);   // signed year order
        send_req(REQ_LESS, 9, 3, 1999, 1, 4, 1999);
        send_req(REQ_LESS, 31, 7, 1999, 30, 7, 1999);
    endtask

    task automatic test_validity();
        send_req(REQ_VALID, 29, 2, 2024, 0, 0, 0);
        send_req(REQ_VALID, 29, 2, 2023, 0, 0, 0);
        send_req(REQ_VALID, 29, 2, -400, 0, 0, 0);       // negative leap year
        send_req(REQ_VALID, 29, 2, 0, 0, 0, 0);
        send_req(REQ_VALID, 31, 4, 2024, 0, 0, 0);
        send_req(REQ_VALID, 1, 0, 2024, 0, 0, 0);
        send_req(REQ_VALID, 0, 1, 2024, 0, 0, 0);
        send_req(REQ_VALID, 31, 1, 2024, 0, 0, 0);
    endtask

    task automatic test_random_requests(input int n);
        repeat (n)
            send_random_req();
    endtask

    task automatic test_drain_pause();
        test_random_requests(10);
        wait_drained();
        test_random_requests(10);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_ADD;
        date_day    = '0;
        date_month  = '0;
        date_year   = '0;
        other_day   = '0;
        other_month = '0;
        other_year  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 55;
        test_add_period();
        test_sub_period();
        test_date_compare();
        test_validity();
        test_random_requests(170);
        test_drain_pause();

        send_idle_pct = 55;
        recv_idle_pct = 36;
        test_random_requests(180);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_requests(170);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_dates.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #400000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
